FILE: design/pcfr_pkg.sv
// Package for the phasor command frame receiver.
// Holds the beat types, header constants, status and command codes and the CRC step.
// No dependencies; every other design file refers to it by scoped names.
package pcfr_pkg;

	// Default for the largest number of bytes of a chunk that are counted and checked.
	localparam int MAX_CHUNK_DEF = 2048;

	// Configuration port.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ID = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_ENFORCE = 1'b1;
	localparam logic [15:0] LOCAL_ID_RST = 16'h0001;

	// Frame constants.
	localparam logic [7:0] SYNC_BYTE = 8'hAA;
	localparam logic [7:0] FRAME_TYPE = 8'h41;
	localparam int MIN_FRAME = 10;
	localparam logic [15:0] BCAST_ID = 16'hFFFF;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Status codes.
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_HEADER = 3'd1;
	localparam logic [2:0] ST_BAD_SIZE = 3'd2;
	localparam logic [2:0] ST_CRC_ERR = 3'd3;
	localparam logic [2:0] ST_ID_MISMATCH = 3'd4;

	// Command codes.
	localparam logic [2:0] CMD_NONE = 3'd0;
	localparam logic [2:0] CMD_OFF = 3'd1;
	localparam logic [2:0] CMD_ON = 3'd2;
	localparam logic [2:0] CMD_HEADER = 3'd3;
	localparam logic [2:0] CMD_CFG1 = 3'd4;
	localparam logic [2:0] CMD_OTHER = 3'd5;

	// One input beat.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       chunk_end;
	} in_beat_t;

	// One result beat.
	typedef struct packed {
		logic [2:0] status;
		logic [2:0] command_code;
		logic       crc_good;
		logic       send_config;
		logic       stream_on;
	} out_beat_t;

	// Captured fields of the chunk under way.
	typedef struct packed {
		logic        header_good;
		logic [15:0] size_field;
		logic [15:0] sender_id;
		logic [15:0] raw_command;
		logic [15:0] trailer_crc;
		logic [15:0] crc_accum;
	} chunk_t;

	// CRC-16-CCITT, MSB first, one byte folded in.
	function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

FILE: design/pcfr_accum.sv
// Input register and per-chunk field capture of the command frame receiver.
// Depends on pcfr_pkg for the beat and chunk types and the CRC step.
module pcfr_accum #(
	parameter int MAX_CHUNK = pcfr_pkg::MAX_CHUNK_DEF,
	localparam int CNT_W = $clog2(MAX_CHUNK + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  pcfr_pkg::in_beat_t beat,
	input  logic               advance,
	output logic               s1_valid,
	output logic               s1_end,
	output pcfr_pkg::chunk_t   chunk_nxt,
	output logic [CNT_W-1:0]   count_nxt
);

	logic               valid_s1;
	pcfr_pkg::in_beat_t beat_s1;
	logic [CNT_W-1:0]   count_q;
	pcfr_pkg::chunk_t   chunk_q;
	logic [16:0]        idx_ext;
	logic               take;

	// Input register: one beat waits here while its fields are folded in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_s1 <= beat;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_end = beat_s1.chunk_end;
	assign idx_ext = 17'(count_q);
	assign take = (count_q < CNT_W'(MAX_CHUNK));

	// Next chunk state with this beat's byte taken in.
	always_comb begin
		chunk_nxt = chunk_q;
		count_nxt = count_q;
		if (take) begin
			if (count_q == CNT_W'(0) && beat_s1.rx_byte != pcfr_pkg::SYNC_BYTE) begin
				chunk_nxt.header_good = 1'b0;
			end
			if (count_q == CNT_W'(1) && beat_s1.rx_byte != pcfr_pkg::FRAME_TYPE) begin
				chunk_nxt.header_good = 1'b0;
			end
			if (count_q == CNT_W'(2)) chunk_nxt.size_field[15:8] = beat_s1.rx_byte;
			if (count_q == CNT_W'(3)) chunk_nxt.size_field[7:0] = beat_s1.rx_byte;
			if (count_q == CNT_W'(4)) chunk_nxt.sender_id[15:8] = beat_s1.rx_byte;
			if (count_q == CNT_W'(5)) chunk_nxt.sender_id[7:0] = beat_s1.rx_byte;
			if (count_q == CNT_W'(6)) chunk_nxt.raw_command[15:8] = beat_s1.rx_byte;
			if (count_q == CNT_W'(7)) chunk_nxt.raw_command[7:0] = beat_s1.rx_byte;
			// The CRC covers the header and everything up to the trailer.
			if (count_q < CNT_W'(4) || idx_ext + 17'd2 < {1'b0, chunk_q.size_field}) begin
				chunk_nxt.crc_accum = pcfr_pkg::crc16_byte(chunk_q.crc_accum, beat_s1.rx_byte);
			end
			if (count_q >= CNT_W'(4) && idx_ext + 17'd2 == {1'b0, chunk_q.size_field}) begin
				chunk_nxt.trailer_crc[15:8] = beat_s1.rx_byte;
			end
			if (count_q >= CNT_W'(4) && idx_ext + 17'd1 == {1'b0, chunk_q.size_field}) begin
				chunk_nxt.trailer_crc[7:0] = beat_s1.rx_byte;
			end
			count_nxt = count_q + CNT_W'(1);
		end
	end

	// Chunk state: updated as each beat leaves the input register, cleared at chunk end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			chunk_q.header_good <= 1'b1;
			chunk_q.size_field <= '0;
			chunk_q.sender_id <= '0;
			chunk_q.raw_command <= '0;
			chunk_q.trailer_crc <= '0;
			chunk_q.crc_accum <= pcfr_pkg::CRC_INIT;
		end else if (advance) begin
			if (beat_s1.chunk_end) begin
				count_q <= '0;
				chunk_q.header_good <= 1'b1;
				chunk_q.size_field <= '0;
				chunk_q.sender_id <= '0;
				chunk_q.raw_command <= '0;
				chunk_q.trailer_crc <= '0;
				chunk_q.crc_accum <= pcfr_pkg::CRC_INIT;
			end else begin
				count_q <= count_nxt;
				chunk_q <= chunk_nxt;
			end
		end
	end

endmodule

FILE: design/pcfr_eval.sv
// Frame verdict of the command frame receiver: status, command and flags.
// Depends on pcfr_pkg for the chunk and result types and the codes.
module pcfr_eval #(
	parameter int MAX_CHUNK = pcfr_pkg::MAX_CHUNK_DEF,
	localparam int CNT_W = $clog2(MAX_CHUNK + 1)
) (
	input  pcfr_pkg::chunk_t    chunk,
	input  logic [CNT_W-1:0]    count,
	input  logic [15:0]         local_id,
	input  logic                crc_enforce,
	output pcfr_pkg::out_beat_t result
);

	logic [2:0] cmd;
	logic       good;

	// Checks run in order: header, size, CRC, station id.
	always_comb begin
		cmd = pcfr_pkg::CMD_NONE;
		good = 1'b0;
		result.status = pcfr_pkg::ST_OK;
		if (count < CNT_W'(pcfr_pkg::MIN_FRAME) || !chunk.header_good) begin
			result.status = pcfr_pkg::ST_BAD_HEADER;
		end else if (chunk.size_field > 16'(count) ||
				chunk.size_field < 16'(pcfr_pkg::MIN_FRAME)) begin
			result.status = pcfr_pkg::ST_BAD_SIZE;
		end else begin
			good = (chunk.trailer_crc == chunk.crc_accum);
			if (crc_enforce && !good) begin
				result.status = pcfr_pkg::ST_CRC_ERR;
			end else if (chunk.sender_id != local_id && chunk.sender_id != pcfr_pkg::BCAST_ID) begin
				result.status = pcfr_pkg::ST_ID_MISMATCH;
			end else if (chunk.raw_command inside {[16'd1:16'd4]}) begin
				cmd = chunk.raw_command[2:0];
			end else begin
				cmd = pcfr_pkg::CMD_OTHER;
			end
		end
		result.command_code = cmd;
		result.crc_good = good;
		result.send_config = !(cmd == pcfr_pkg::CMD_OFF || cmd == pcfr_pkg::CMD_ON);
		result.stream_on = (cmd != pcfr_pkg::CMD_OFF);
	end

endmodule

FILE: design/pcfr_out_reg.sv
// Result register of the command frame receiver with a valid/ready output side.
// Depends on pcfr_pkg for the result type.
module pcfr_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  pcfr_pkg::out_beat_t result,
	output logic                slot_free,
	output logic                out_valid,
	input  logic                out_ready,
	output pcfr_pkg::out_beat_t out_data
);

	logic                out_valid_q;
	pcfr_pkg::out_beat_t out_q;

	// A held result leaves in the same cycle that a new one may be loaded.
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

FILE: design/phasor_command_frame_receiver.sv
// Top level of the phasor command frame receiver.
// Depends on pcfr_pkg, pcfr_accum, pcfr_eval and pcfr_out_reg.
//
// The receiver takes one byte beat per clock and gives one result beat for
// each beat flagged chunk_end, once that beat has passed the input register
// and the result register: the byte waits in the input register, where its
// fields and the bytewise CRC update are folded into the chunk state and,
// on the last byte, the verdict is formed and loaded into the result
// register. A result held in the result register does not stop ordinary
// bytes; only a further last byte waits, in the input register, until the
// held result is taken. Bytes beyond the first MAX_CHUNK of a chunk are
// not counted or checked, but their chunk_end still closes the chunk. Write
// local_id and crc_enforce only while no chunk is in flight.
module phasor_command_frame_receiver #(
	parameter int MAX_CHUNK = pcfr_pkg::MAX_CHUNK_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  pcfr_pkg::in_beat_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pcfr_pkg::out_beat_t              out_data,
	input  logic                             cfg_we,
	input  logic [pcfr_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [pcfr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_CHUNK + 1);

	logic [15:0]         local_id_q;
	logic                crc_enforce_q;
	logic                s1_valid;
	logic                s1_end;
	logic                slot_free;
	logic                advance;
	logic                in_load;
	pcfr_pkg::chunk_t    chunk_nxt;
	logic [CNT_W-1:0]    count_nxt;
	pcfr_pkg::out_beat_t result;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_id_q <= pcfr_pkg::LOCAL_ID_RST;
			crc_enforce_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				pcfr_pkg::REG_LOCAL_ID: local_id_q <= cfg_wdata[15:0];
				pcfr_pkg::REG_CRC_ENFORCE: crc_enforce_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// A beat leaves the input register unless it is a last byte facing a full result slot.
	assign advance = s1_valid && (!s1_end || slot_free);
	assign in_ready = !s1_valid || advance;
	assign in_load = in_valid && in_ready;

	pcfr_accum #(.MAX_CHUNK(MAX_CHUNK)) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_load),
		.beat      (in_data),
		.advance   (advance),
		.s1_valid  (s1_valid),
		.s1_end    (s1_end),
		.chunk_nxt (chunk_nxt),
		.count_nxt (count_nxt)
	);

	pcfr_eval #(.MAX_CHUNK(MAX_CHUNK)) u_eval (
		.chunk       (chunk_nxt),
		.count       (count_nxt),
		.local_id    (local_id_q),
		.crc_enforce (crc_enforce_q),
		.result      (result)
	);

	pcfr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && s1_end),
		.result    (result),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: design/pcfr_checker.sv
// Port-level checks for the phasor command frame receiver, bound to the top level.
// Depends on pcfr_pkg for the result type and codes.
module pcfr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input pcfr_pkg::out_beat_t out_data
);

	// A result beat that is not taken stays, unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed while stalled");

	// A command is reported exactly when the frame passed every check.
	a_cmd_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.status == pcfr_pkg::ST_OK) ==
			(out_data.command_code != pcfr_pkg::CMD_NONE)))
		else $error("command code disagrees with status");

	// Flags follow from the command code.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.stream_on == (out_data.command_code != pcfr_pkg::CMD_OFF)) &&
			(out_data.send_config == !(out_data.command_code == pcfr_pkg::CMD_OFF ||
				out_data.command_code == pcfr_pkg::CMD_ON)))
		else $error("send_config or stream_on inconsistent with command");

	// No CRC is judged good when the header or size failed or a CRC error is reported.
	a_crc_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == pcfr_pkg::ST_BAD_HEADER ||
			out_data.status == pcfr_pkg::ST_BAD_SIZE ||
			out_data.status == pcfr_pkg::ST_CRC_ERR) |-> !out_data.crc_good)
		else $error("crc_good set with a failing status");

	// Status stays within the defined codes.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= pcfr_pkg::ST_ID_MISMATCH)
		else $error("undefined status code");

endmodule

bind phasor_command_frame_receiver pcfr_checker u_pcfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

FILE: test/phasor_command_frame_receiver_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the phasor command frame receiver.
// Depends on pcfr_pkg and the phasor_command_frame_receiver top level.
// A scoreboard class predicts each chunk verdict and checks the result beats.
module phasor_command_frame_receiver_test;

	localparam int MAX_BYTES = pcfr_pkg::MAX_CHUNK_DEF;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;

	// Verdict predictor and store of verdicts still owed by the block.
	class frame_scoreboard;
		logic [15:0]         station_id;
		bit                  check_crc;
		int                  taken;
		logic [15:0]         crc_run;
		bit                  header_ok;
		logic [15:0]         frame_size;
		logic [15:0]         source_id;
		logic [15:0]         command_word;
		logic [15:0]         trailer_word;
		bit                  streaming;
		pcfr_pkg::out_beat_t pending_verdicts[$];
		int                  failures;
		int                  verdict_tally[5];

		function new();
			station_id = pcfr_pkg::LOCAL_ID_RST;
			check_crc = 1'b1;
			streaming = 1'b0;
			failures = 0;
			foreach (verdict_tally[k]) verdict_tally[k] = 0;
			clear_chunk();
		endfunction

		// CCITT polynomial, most significant bit first.
		static function logic [15:0] crc_fold(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c ^ {b, 8'h00};
			for (int k = 0; k < 8; k++) begin
				if (r[15]) begin
					r = {r[14:0], 1'b0} ^ pcfr_pkg::CRC_POLY;
				end else begin
					r = {r[14:0], 1'b0};
				end
			end
			return r;
		endfunction

		function void clear_chunk();
			taken = 0;
			crc_run = pcfr_pkg::CRC_INIT;
			header_ok = 1'b1;
			frame_size = '0;
			source_id = '0;
			command_word = '0;
			trailer_word = '0;
		endfunction

		// Folds one accepted byte beat in; a last byte produces a verdict.
		function void note_input(pcfr_pkg::in_beat_t beat);
			int                  i;
			int                  sz;
			pcfr_pkg::out_beat_t v;
			i = taken;
			sz = int'(frame_size);
			if (i < MAX_BYTES) begin
				if (i == 0 && beat.rx_byte != pcfr_pkg::SYNC_BYTE) header_ok = 1'b0;
				if (i == 1 && beat.rx_byte != pcfr_pkg::FRAME_TYPE) header_ok = 1'b0;
				if (i == 2) frame_size[15:8] = beat.rx_byte;
				if (i == 3) frame_size[7:0] = beat.rx_byte;
				if (i == 4) source_id[15:8] = beat.rx_byte;
				if (i == 5) source_id[7:0] = beat.rx_byte;
				if (i == 6) command_word[15:8] = beat.rx_byte;
				if (i == 7) command_word[7:0] = beat.rx_byte;
				if (i < 4 || i + 2 < sz) crc_run = crc_fold(crc_run, beat.rx_byte);
				if (i >= 4 && i + 2 == sz) trailer_word[15:8] = beat.rx_byte;
				if (i >= 4 && i + 1 == sz) trailer_word[7:0] = beat.rx_byte;
				taken = i + 1;
			end
			if (!beat.chunk_end) return;

			// Checks in order: header, size, CRC, station id.
			v = '0;
			v.status = pcfr_pkg::ST_OK;
			v.command_code = pcfr_pkg::CMD_NONE;
			sz = int'(frame_size);
			if (taken < pcfr_pkg::MIN_FRAME || !header_ok) begin
				v.status = pcfr_pkg::ST_BAD_HEADER;
			end else if (sz > taken || sz < pcfr_pkg::MIN_FRAME) begin
				v.status = pcfr_pkg::ST_BAD_SIZE;
			end else begin
				v.crc_good = (trailer_word == crc_run);
				if (check_crc && !v.crc_good) begin
					v.status = pcfr_pkg::ST_CRC_ERR;
				end else if (source_id != station_id && source_id != pcfr_pkg::BCAST_ID) begin
					v.status = pcfr_pkg::ST_ID_MISMATCH;
				end else begin
					case (command_word)
						16'd1: v.command_code = pcfr_pkg::CMD_OFF;
						16'd2: v.command_code = pcfr_pkg::CMD_ON;
						16'd3: v.command_code = pcfr_pkg::CMD_HEADER;
						16'd4: v.command_code = pcfr_pkg::CMD_CFG1;
						default: v.command_code = pcfr_pkg::CMD_OTHER;
					endcase
				end
			end
			streaming = (v.command_code != pcfr_pkg::CMD_OFF);
			v.stream_on = streaming;
			v.send_config = !(v.command_code == pcfr_pkg::CMD_OFF ||
				v.command_code == pcfr_pkg::CMD_ON);
			pending_verdicts.insert(pending_verdicts.size(), v);
			clear_chunk();
		endfunction

		function void compare_field(string field, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				failures++;
			end
		endfunction

		// Compares one result beat with the oldest owed verdict.
		function void check_result(pcfr_pkg::out_beat_t got);
			pcfr_pkg::out_beat_t want;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual status %0d",
					$time, got.status);
				failures++;
				return;
			end
			want = pending_verdicts.pop_front();
			verdict_tally[want.status]++;
			compare_field("status", int'(want.status), int'(got.status));
			compare_field("command_code", int'(want.command_code), int'(got.command_code));
			compare_field("crc_good", int'(want.crc_good), int'(got.crc_good));
			compare_field("send_config", int'(want.send_config), int'(got.send_config));
			compare_field("stream_on", int'(want.stream_on), int'(got.stream_on));
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	pcfr_pkg::in_beat_t              in_data = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	pcfr_pkg::out_beat_t             out_data;
	logic                            cfg_we = 1'b0;
	logic [pcfr_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [pcfr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	frame_scoreboard sb = new();
	logic [7:0]      chunk_buf[$];
	int              bytes_sent = 0;
	int              chunks_sent = 0;
	bit              gaps_on = 1'b1;
	bit              quiet = 1'b0;
	bit              hold_req = 1'b0;

	phasor_command_frame_receiver #(
		.MAX_CHUNK(MAX_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result side: random stall bursts, one long hold-off on request, none at the end.
	initial begin
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Every accepted result beat goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// Ends the run when no beat has moved on either side for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// Appends one byte to the chunk being built.
	function automatic void add_byte(logic [7:0] b);
		chunk_buf.insert(chunk_buf.size(), b);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Offers one byte beat and waits until it is taken.
	task automatic send_beat(input pcfr_pkg::in_beat_t beat);
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(beat);
		bytes_sent++;
	endtask

	// Sends the bytes in chunk_buf, flagging the last one.
	task automatic send_chunk();
		pcfr_pkg::in_beat_t beat;
		for (int k = 0; k < chunk_buf.size(); k++) begin
			if (gaps_on && $urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			beat.rx_byte = chunk_buf[k];
			beat.chunk_end = (k == chunk_buf.size() - 1);
			send_beat(beat);
		end
		chunks_sent++;
	endtask

	// Waits until every owed verdict has come back and the block has settled.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pcfr_pkg::CFG_IDX_W-1:0] idx,
			input logic [pcfr_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == pcfr_pkg::REG_LOCAL_ID) begin
			sb.station_id = value;
		end else begin
			sb.check_crc = value[0];
		end
		@(posedge clk);
	endtask

	// Builds a well-formed frame with random payload, optionally a bad trailer,
	// followed by extra trailing bytes.
	function automatic void make_frame(int size, logic [15:0] id, logic [15:0] cmd,
			int extra, bit bad_crc);
		logic [15:0] sz;
		logic [15:0] crc;
		sz = size[15:0];
		chunk_buf.delete();
		add_byte(pcfr_pkg::SYNC_BYTE);
		add_byte(pcfr_pkg::FRAME_TYPE);
		add_byte(sz[15:8]);
		add_byte(sz[7:0]);
		add_byte(id[15:8]);
		add_byte(id[7:0]);
		add_byte(cmd[15:8]);
		add_byte(cmd[7:0]);
		while (chunk_buf.size() < size - 2) add_byte(rand_byte());
		crc = pcfr_pkg::CRC_INIT;
		foreach (chunk_buf[k]) crc = frame_scoreboard::crc_fold(crc, chunk_buf[k]);
		if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
		add_byte(crc[15:8]);
		add_byte(crc[7:0]);
		repeat (extra) add_byte(rand_byte());
	endfunction

	function automatic void truncate_chunk(int n);
		while (chunk_buf.size() > n) void'(chunk_buf.pop_back());
	endfunction

	task automatic send_frame(int size, logic [15:0] id, logic [15:0] cmd,
			int extra, bit bad_crc);
		make_frame(size, id, cmd, extra, bad_crc);
		send_chunk();
	endtask

	function automatic logic [15:0] pick_command();
		case ($urandom_range(0, 7))
			0: return {13'd0, pcfr_pkg::CMD_OFF};
			1: return {13'd0, pcfr_pkg::CMD_ON};
			2: return {13'd0, pcfr_pkg::CMD_HEADER};
			3: return {13'd0, pcfr_pkg::CMD_CFG1};
			4: return {13'd0, pcfr_pkg::CMD_OTHER};
			5: return 16'd0;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Mostly well-formed frames, the rest damaged in one way or pure noise.
	function automatic void make_random_chunk();
		int          r;
		int          len;
		logic [15:0] id;
		logic [15:0] bad_size;
		r = int'($urandom_range(0, 99));
		id = ($urandom_range(0, 4) != 0) ? sb.station_id : pcfr_pkg::BCAST_ID;
		make_frame(int'($urandom_range(10, 20)), id, pick_command(),
			($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 4)) : 0,
			$urandom_range(0, 9) == 0);
		len = chunk_buf.size();
		if (r < 55) begin
			return;
		end else if (r < 65) begin
			chunk_buf[4] = rand_byte();
			chunk_buf[5] = rand_byte();
		end else if (r < 72) begin
			chunk_buf[$urandom_range(0, 1)] = rand_byte();
		end else if (r < 80) begin
			if ($urandom_range(0, 1) == 0) begin
				bad_size = 16'($urandom_range(0, pcfr_pkg::MIN_FRAME - 1));
			end else begin
				bad_size = 16'($urandom_range(len + 1, len + 40));
			end
			chunk_buf[2] = bad_size[15:8];
			chunk_buf[3] = bad_size[7:0];
		end else if (r < 88) begin
			truncate_chunk(int'($urandom_range(1, len - 1)));
		end else begin
			chunk_buf.delete();
			repeat ($urandom_range(1, 24)) add_byte(rand_byte());
			if (chunk_buf.size() >= 2 && $urandom_range(0, 1) == 0) begin
				chunk_buf[0] = pcfr_pkg::SYNC_BYTE;
				chunk_buf[1] = pcfr_pkg::FRAME_TYPE;
			end
		end
	endfunction

	task automatic run_random(int n_bytes);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			make_random_chunk();
			send_chunk();
		end
		drain();
	endtask

	// Main sequence: reset, directed chunks, then random phases per setting.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every command code, broadcast id and unknown codes, at reset settings.
		send_frame(10, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_OFF}, 0, 0);
		send_frame(12, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_ON}, 0, 0);
		send_frame(14, pcfr_pkg::BCAST_ID, {13'd0, pcfr_pkg::CMD_HEADER}, 0, 0);
		send_frame(10, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_CFG1}, 0, 0);
		send_frame(10, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_OTHER}, 0, 0);
		send_frame(11, pcfr_pkg::LOCAL_ID_RST, 16'h0000, 0, 0);
		send_frame(10, pcfr_pkg::BCAST_ID, 16'hFFFF, 0, 0);

		// Bad sync, bad type, short chunk and a single-byte chunk.
		make_frame(10, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_ON}, 0, 0);
		chunk_buf[0] = 8'h55;
		send_chunk();
		make_frame(10, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_ON}, 0, 0);
		chunk_buf[1] = 8'h42;
		send_chunk();
		make_frame(10, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_ON}, 0, 0);
		truncate_chunk(9);
		send_chunk();
		make_frame(10, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_ON}, 0, 0);
		truncate_chunk(1);
		send_chunk();

		// Size beyond the chunk, a short size field, zero and all-ones size.
		make_frame(20, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_ON}, 0, 0);
		truncate_chunk(12);
		send_chunk();
		make_frame(10, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_ON}, 0, 0);
		chunk_buf[3] = 8'd8;
		send_chunk();
		make_frame(10, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_ON}, 0, 0);
		chunk_buf[2] = 8'h00;
		chunk_buf[3] = 8'h00;
		send_chunk();
		make_frame(10, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_ON}, 0, 0);
		chunk_buf[2] = 8'hFF;
		chunk_buf[3] = 8'hFF;
		send_chunk();

		// Trailing bytes, enforced CRC error, station id mismatch.
		send_frame(10, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_ON}, 5, 0);
		send_frame(12, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_HEADER}, 0, 1);
		send_frame(10, 16'h0002, {13'd0, pcfr_pkg::CMD_CFG1}, 0, 0);
		send_frame(10, 16'h0000, {13'd0, pcfr_pkg::CMD_CFG1}, 0, 0);
		drain();

		// Station 0 with CRC not enforced.
		write_reg(pcfr_pkg::REG_LOCAL_ID, 16'h0000);
		write_reg(pcfr_pkg::REG_CRC_ENFORCE, 16'h0000);
		send_frame(12, 16'h0000, {13'd0, pcfr_pkg::CMD_ON}, 0, 1);
		send_frame(10, pcfr_pkg::LOCAL_ID_RST, {13'd0, pcfr_pkg::CMD_OFF}, 0, 0);
		send_frame(10, 16'h0000, {13'd0, pcfr_pkg::CMD_OFF}, 0, 0);
		run_random(60);

		// Station id equal to broadcast, CRC enforced.
		write_reg(pcfr_pkg::REG_LOCAL_ID, pcfr_pkg::BCAST_ID);
		write_reg(pcfr_pkg::REG_CRC_ENFORCE, 16'h0001);
		run_random(60);

		write_reg(pcfr_pkg::REG_LOCAL_ID, 16'($urandom_range(0, 65535)));
		write_reg(pcfr_pkg::REG_CRC_ENFORCE, 16'h0000);
		run_random(60);

		// Long receiver hold-off while minimal frames keep coming.
		write_reg(pcfr_pkg::REG_LOCAL_ID, 16'($urandom_range(0, 65535)));
		write_reg(pcfr_pkg::REG_CRC_ENFORCE, 16'h0001);
		gaps_on = 1'b0;
		hold_req = 1'b1;
		repeat (8) send_frame(10, sb.station_id, pick_command(), 0, 0);
		drain();

		// Closing stretch with no idling on either side.
		quiet = 1'b1;
		run_random(50);
		repeat (8) @(posedge clk);

		if (sb.pending_verdicts.size() != 0) begin
			$display("%0t: %0d verdicts never arrived", $time, sb.pending_verdicts.size());
			sb.failures++;
		end
		$display("Sent %0d byte beats in %0d chunks under five register settings.",
			bytes_sent, chunks_sent);
		$display("Verdicts ok %0d, header %0d, size %0d, crc %0d, id %0d.",
			sb.verdict_tally[pcfr_pkg::ST_OK], sb.verdict_tally[pcfr_pkg::ST_BAD_HEADER],
			sb.verdict_tally[pcfr_pkg::ST_BAD_SIZE], sb.verdict_tally[pcfr_pkg::ST_CRC_ERR],
			sb.verdict_tally[pcfr_pkg::ST_ID_MISMATCH]);
		if (sb.failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
